// File: sv/lapmf_pkg.sv
// shared types, constants and the laplacian arithmetic for the 3x3 laplacian filter
// no dependencies
`default_nettype none

package lapmf_pkg;

    // fixed field widths
    localparam int PIXEL_W     = 8;
    localparam int DIM_W       = 11;
    localparam int COORD_W     = 10;
    localparam int GAIN_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // largest frame dimension handled by the counters
    localparam int DIM_LIMIT = 1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_OUTPUT_GAIN  = 2'd2
    } t_cfg_idx;

    // register defaults
    localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(512);
    localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(512);
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(7);

    // gain * |up + down + left + right - 4 * centre|, saturated to a pixel
    function automatic logic [PIXEL_W-1:0] lap_value(
        input logic [PIXEL_W-1:0] up,
        input logic [PIXEL_W-1:0] dn,
        input logic [PIXEL_W-1:0] lf,
        input logic [PIXEL_W-1:0] rt,
        input logic [PIXEL_W-1:0] ctr,
        input logic [GAIN_W-1:0]  gain
    );
        logic [PIXEL_W+1:0]        pos;
        logic [PIXEL_W+1:0]        neg;
        logic [PIXEL_W+1:0]        mag;
        logic [PIXEL_W+GAIN_W+1:0] prod;
        pos = (PIXEL_W+2)'(up) + (PIXEL_W+2)'(dn) + (PIXEL_W+2)'(lf) + (PIXEL_W+2)'(rt);
        neg = {ctr, 2'b00};
        mag = (pos >= neg) ? (pos - neg) : (neg - pos);
        prod = (PIXEL_W+GAIN_W+2)'(mag) * (PIXEL_W+GAIN_W+2)'(gain);
        if (prod > (PIXEL_W+GAIN_W+2)'({PIXEL_W{1'b1}})) begin
            lap_value = {PIXEL_W{1'b1}};
        end else begin
            lap_value = prod[PIXEL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/laplacian_3x3_mirror_filter_core.sv
// a taken pixel request passes stage a, then stage b, then the output register; stalls can hold it
// throughput: one pixel request per cycle unless o_in_stall is high; a pixel with two results
// (row end or last row) or four (last pixel of the frame) holds the input until all are sent
// reset (synchronous, active low): counters, window, pipeline valids and config to defaults;
// line stores are not cleared
// top level: config, position counters, window and result sequencing; uses lapmf_pkg
`default_nettype none

module laplacian_3x3_mirror_filter_core #(
    parameter int MAX_WIDTH = lapmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [lapmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lapmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [lapmf_pkg::PIXEL_W-1:0]    i_pixel_in,
    // result output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [lapmf_pkg::PIXEL_W-1:0]    o_edge_value,
    output logic      [lapmf_pkg::COORD_W-1:0]    o_out_row,
    output logic      [lapmf_pkg::COORD_W-1:0]    o_out_col,
    output logic                                  o_frame_last
);
    import lapmf_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WMAX = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;

    // configuration registers
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;
    logic [GAIN_W-1:0] r_output_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
            r_output_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                CFG_OUTPUT_GAIN:  r_output_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size and position of the incoming pixel
    logic [DIM_W-1:0]   w_clamp;
    logic [DIM_W-1:0]   h_clamp;
    logic [COORD_W-1:0] w_last;
    logic [COORD_W-1:0] h_last;
    logic [COORD_W-1:0] r_col_cnt;
    logic [COORD_W-1:0] r_row_cnt;
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] cur_row;
    logic               cur_end_col;
    logic               cur_end_row;

    always_comb begin
        if (r_image_width < DIM_W'(2)) begin
            w_clamp = DIM_W'(2);
        end else if (r_image_width > DIM_W'(WMAX)) begin
            w_clamp = DIM_W'(WMAX);
        end else begin
            w_clamp = r_image_width;
        end
        if (r_image_height < DIM_W'(2)) begin
            h_clamp = DIM_W'(2);
        end else if (r_image_height > DIM_W'(DIM_LIMIT)) begin
            h_clamp = DIM_W'(DIM_LIMIT);
        end else begin
            h_clamp = r_image_height;
        end
        w_last      = COORD_W'(w_clamp - DIM_W'(1));
        h_last      = COORD_W'(h_clamp - DIM_W'(1));
        cur_col     = (r_col_cnt > w_last) ? w_last : r_col_cnt;
        cur_row     = (r_row_cnt > h_last) ? h_last : r_row_cnt;
        cur_end_col = (cur_col == w_last);
        cur_end_row = (cur_row == h_last);
    end

    // pipeline handshake
    logic in_acc;
    logic a_adv;
    logic r_a_valid;
    logic r_b_valid;
    logic b_done;

    assign o_in_stall = r_a_valid && !a_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign a_adv      = r_a_valid && (!r_b_valid || b_done);

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            if (cur_end_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= cur_end_row ? '0 : cur_row + COORD_W'(1);
            end else begin
                r_col_cnt <= cur_col + COORD_W'(1);
                r_row_cnt <= cur_row;
            end
        end
    end

    // stage a: pixel and position beside the line store read
    logic [PIXEL_W-1:0] r_a_px;
    logic [COORD_W-1:0] r_a_col;
    logic [COORD_W-1:0] r_a_row;
    logic               r_a_end_col;
    logic               r_a_end_row;
    logic [PIXEL_W-1:0] rd_above;
    logic [PIXEL_W-1:0] rd_two;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_px      <= i_pixel_in;
            r_a_col     <= cur_col;
            r_a_row     <= cur_row;
            r_a_end_col <= cur_end_col;
            r_a_end_row <= cur_end_row;
        end
    end

    // line stores: read on request, write back when the pixel enters the window
    lapmf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rd_en    (in_acc),
        .i_rd_addr  (AW'(cur_col)),
        .i_wr_en    (a_adv),
        .i_wr_addr  (AW'(r_a_col)),
        .i_wr_above (r_a_px),
        .i_wr_two   (rd_above),
        .o_rd_above (rd_above),
        .o_rd_two   (rd_two)
    );

    // stage b: 3x3 window, indexed [column slot c-2,c-1,c][row slot R-2,R-1,R]
    logic [PIXEL_W-1:0] r_win [3][3];
    logic [3:0]         r_b_pend;
    logic [COORD_W-1:0] r_b_col;
    logic [COORD_W-1:0] r_b_row;
    logic               r_b_top;
    logic               r_b_left;
    logic               a_gen;

    assign a_gen = (r_a_row != '0) && (r_a_col != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (a_adv) begin
            for (int j = 0; j < 3; j++) begin
                r_win[0][j] <= r_win[1][j];
                r_win[1][j] <= r_win[2][j];
            end
            r_win[2][0] <= rd_two;
            r_win[2][1] <= rd_above;
            r_win[2][2] <= r_a_px;
        end
    end

    // result selection: lowest pending of (R-1,c-1), (R,c-1), (R-1,c), (R,c)
    logic [3:0]         sel_hot;
    logic [1:0]         sel;
    logic               emit;
    logic               out_free;
    logic [3:0]         n_b_pend;
    logic [PIXEL_W-1:0] up_l;
    logic [PIXEL_W-1:0] up_c;
    logic [PIXEL_W-1:0] op_up;
    logic [PIXEL_W-1:0] op_dn;
    logic [PIXEL_W-1:0] op_lf;
    logic [PIXEL_W-1:0] op_rt;
    logic [PIXEL_W-1:0] op_ctr;
    logic [COORD_W-1:0] res_row;
    logic [COORD_W-1:0] res_col;
    logic               res_last;

    always_comb begin
        if (r_b_pend[0]) begin
            sel = 2'd0;
        end else if (r_b_pend[1]) begin
            sel = 2'd1;
        end else if (r_b_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        sel_hot  = 4'b0001 << sel;
        out_free = !o_out_valid || !i_out_stall;
        emit     = r_b_valid && (r_b_pend != '0) && out_free;
        n_b_pend = emit ? (r_b_pend & ~sel_hot) : r_b_pend;
        b_done   = r_b_valid && (n_b_pend == '0);

        // mirrored neighbours: row -1 reads row 1, column -1 reads column 1
        up_l = r_b_top ? r_win[1][2] : r_win[1][0];
        up_c = r_b_top ? r_win[2][2] : r_win[2][0];

        case (sel)
            2'd0: begin
                op_ctr = r_win[1][1];
                op_up  = up_l;
                op_dn  = r_win[1][2];
                op_lf  = r_b_left ? r_win[2][1] : r_win[0][1];
                op_rt  = r_win[2][1];
                res_row = r_b_row - COORD_W'(1);
                res_col = r_b_col - COORD_W'(1);
                res_last = 1'b0;
            end
            2'd1: begin
                op_ctr = r_win[1][2];
                op_up  = r_win[1][1];
                op_dn  = r_win[1][1];
                op_lf  = r_b_left ? r_win[2][2] : r_win[0][2];
                op_rt  = r_win[2][2];
                res_row = r_b_row;
                res_col = r_b_col - COORD_W'(1);
                res_last = 1'b0;
            end
            2'd2: begin
                op_ctr = r_win[2][1];
                op_up  = up_c;
                op_dn  = r_win[2][2];
                op_lf  = r_win[1][1];
                op_rt  = r_win[1][1];
                res_row = r_b_row - COORD_W'(1);
                res_col = r_b_col;
                res_last = 1'b0;
            end
            default: begin
                op_ctr = r_win[2][2];
                op_up  = r_win[2][1];
                op_dn  = r_win[2][1];
                op_lf  = r_win[1][2];
                op_rt  = r_win[1][2];
                res_row = r_b_row;
                res_col = r_b_col;
                res_last = 1'b1;
            end
        endcase
    end

    // stage b control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
            r_b_pend  <= {a_gen && r_a_end_col && r_a_end_row, a_gen && r_a_end_col,
                          a_gen && r_a_end_row, a_gen};
        end else if (b_done) begin
            r_b_valid <= 1'b0;
            r_b_pend  <= '0;
        end else begin
            r_b_pend  <= n_b_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_col  <= r_a_col;
            r_b_row  <= r_a_row;
            r_b_top  <= (r_a_row == COORD_W'(1));
            r_b_left <= (r_a_col == COORD_W'(1));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_edge_value <= lap_value(op_up, op_dn, op_lf, op_rt, op_ctr, r_output_gain);
            o_out_row    <= res_row;
            o_out_col    <= res_col;
            o_frame_last <= res_last;
        end
    end

endmodule

`default_nettype wire

// File: sv/lapmf_line_buf.sv
// two line stores (row above, two rows above) with registered read
// depends on lapmf_pkg
`default_nettype none

module lapmf_line_buf #(
    parameter int MAX_WIDTH = lapmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  wire logic [lapmf_pkg::PIXEL_W-1:0] i_wr_above,
    input  wire logic [lapmf_pkg::PIXEL_W-1:0] i_wr_two,
    output logic      [lapmf_pkg::PIXEL_W-1:0] o_rd_above,
    output logic      [lapmf_pkg::PIXEL_W-1:0] o_rd_two
);
    import lapmf_pkg::*;

    logic [PIXEL_W-1:0] r_above_mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] r_two_mem   [MAX_WIDTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_above_mem[i_wr_addr] <= i_wr_above;
            r_two_mem[i_wr_addr]   <= i_wr_two;
        end
    end

    // registered read, held while no new request is taken
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_above <= r_above_mem[i_rd_addr];
            o_rd_two   <= r_two_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
